// File: rtl/twa_pkg.sv
// Shared constants, types and controller codes for the windowed throughput meter.
// Used by every module of the block but twa_ram; depends on nothing.
package twa_pkg;

	// Window length and the widths that follow from it.
	localparam int WINDOW = 100;
	localparam int CNT_W  = $clog2(WINDOW + 1);
	localparam int HEAD_W = (WINDOW > 2) ? $clog2(WINDOW) : 1;

	// Field widths of the ports.
	localparam int RATE_W = 32;
	localparam int AVG_W  = 48;
	localparam int FRAC_W = 16;
	localparam int HELD_W = 7;

	// Rate scaling from microseconds to seconds.
	localparam int                 SCALE_W    = 20;
	localparam logic [SCALE_W-1:0] RATE_SCALE = SCALE_W'(1000000);
	localparam int                 PROD_W     = RATE_W + SCALE_W;

	// Divider widths: the dividend covers both the scaled byte count and the
	// weighted sum of the cumulative average.
	localparam int SUM_W  = AVG_W + CNT_W;
	localparam int DIV_NW = (SUM_W > PROD_W) ? SUM_W : PROD_W;
	localparam int DIV_DW = 32;

	localparam logic [RATE_W-1:0] MAX_RATE = {RATE_W{1'b1}};
	localparam logic [AVG_W-1:0]  MAX_AVG  = {AVG_W{1'b1}};

	// Controller states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_RATE_GO,
		ST_RATE_WAIT,
		ST_AVG_PREP,
		ST_AVG_GO,
		ST_AVG_WAIT,
		ST_UPDATE,
		ST_RESULT
	} twa_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_in;
		logic mul;
		logic div_start;
		logic div_avg;
		logic rate_take;
		logic update;
		logic out_load;
	} twa_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic us_zero;
		logic div_busy;
		logic div_done;
		logic out_free;
	} twa_sts_t;

endpackage

// File: rtl/twa_ram.sv
// Generic single-write, single-read memory with a registered read port.
// Stand-alone; no package dependency.
module twa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 100
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/twa_div.sv
// Restoring radix-2 divider, one quotient bit per cycle, shared by both divisions.
// Depends on twa_pkg for the dividend and divisor widths.
module twa_div import twa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_NW-1:0] dividend,
	input  logic [DIV_DW-1:0] divisor,
	output logic              busy,
	output logic              done,
	output logic [DIV_NW-1:0] quotient
);

	localparam int ITER_W = $clog2(DIV_NW + 1);

	logic              busy_q;
	logic [ITER_W-1:0] iter_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] dvs_q;
	logic [DIV_NW-1:0] quo_q;
	logic [DIV_DW:0]   rem_sh;
	logic [DIV_DW:0]   rem_sub;
	logic              fits;

	// One trial subtraction per cycle.
	always_comb begin
		rem_sh  = {rem_q, quo_q[DIV_NW-1]};
		rem_sub = rem_sh - {1'b0, dvs_q};
		fits    = (rem_sh >= {1'b0, dvs_q});
	end

	// Control: iteration counter and busy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			iter_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			iter_q <= ITER_W'(DIV_NW);
		end else if (busy_q) begin
			iter_q <= iter_q - 1'b1;
			if (iter_q == ITER_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Operand registers: the quotient shifts in as the dividend shifts out.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sub[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
			quo_q <= {quo_q[DIV_NW-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign done     = busy_q && (iter_q == ITER_W'(1));
	assign quotient = quo_q;

	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done && !start |=> !busy)
		else $error("divider still busy after its last iteration");

endmodule

// File: rtl/twa_datapath.sv
// Datapath of the throughput meter: operand registers, multipliers, divider,
// sample ring, window state and the output register. Depends on twa_pkg,
// twa_div and twa_ram.
module twa_datapath import twa_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  twa_cmd_t           cmd,
	output twa_sts_t           sts,
	input  logic [RATE_W-1:0]  byte_count,
	input  logic [31:0]        elapsed_us,
	input  logic               out_stall,
	output logic               out_valid,
	output logic [RATE_W-1:0]  sample_rate,
	output logic [AVG_W-1:0]   average_rate,
	output logic [HELD_W-1:0]  samples_held,
	output logic               bad_sample
);

	// Beat registers and intermediate results.
	logic [RATE_W-1:0] bytes_q;
	logic [DIV_DW-1:0] us_q;
	logic [PROD_W-1:0] prod_q;
	logic [DIV_NW-1:0] mac_q;
	logic [RATE_W-1:0] rate_q;

	// Window state.
	logic [AVG_W-1:0]  avg_q;
	logic [CNT_W-1:0]  count_q;
	logic [HEAD_W-1:0] head_q;

	// Output register.
	logic              out_valid_q;
	logic [RATE_W-1:0] out_rate_q;
	logic [AVG_W-1:0]  out_avg_q;
	logic [CNT_W-1:0]  out_cnt_q;
	logic              out_bad_q;

	logic [RATE_W-1:0] oldest;
	logic [DIV_NW-1:0] div_dividend;
	logic [DIV_DW-1:0] div_divisor;
	logic              div_busy;
	logic              div_done;
	logic [DIV_NW-1:0] quotient;
	logic              full;
	logic              rising;
	logic [RATE_W-1:0] diff_mag;
	logic [RATE_W-1:0] rate_sat;
	logic [AVG_W-1:0]  mag;
	logic [AVG_W:0]    avg_sum;
	logic [AVG_W-1:0]  avg_next;

	assign full = (count_q == CNT_W'(WINDOW));

	// Capture the beat, then form bytes * 1e6 in its own cycle.
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			bytes_q <= byte_count;
			us_q    <= elapsed_us;
		end
		if (cmd.mul) begin
			prod_q <= PROD_W'(bytes_q) * PROD_W'(RATE_SCALE);
		end
		if (cmd.rate_take) begin
			rate_q <= rate_sat;
			mac_q  <= DIV_NW'(count_q) * DIV_NW'(avg_q);
		end
	end

	// The interval rate saturates to 32 bits.
	assign rate_sat = (|quotient[DIV_NW-1:RATE_W]) ? MAX_RATE : quotient[RATE_W-1:0];

	// Divider operand selection: the rate, then either the cumulative average
	// or the windowed change.
	always_comb begin
		rising   = (rate_q >= oldest);
		diff_mag = rising ? (rate_q - oldest) : (oldest - rate_q);
		if (!cmd.div_avg) begin
			div_dividend = DIV_NW'(prod_q);
			div_divisor  = us_q;
		end else if (full) begin
			div_dividend = DIV_NW'({diff_mag, {FRAC_W{1'b0}}});
			div_divisor  = DIV_DW'(WINDOW);
		end else begin
			div_dividend = mac_q + DIV_NW'({rate_q, {FRAC_W{1'b0}}});
			div_divisor  = DIV_DW'(count_q) + DIV_DW'(1);
		end
	end

	twa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (quotient)
	);

	// Sample ring; the read port always shows the slot at the head, which is
	// the oldest sample once the window is full.
	twa_ram #(
		.WIDTH (RATE_W),
		.DEPTH (WINDOW)
	) u_ring (
		.clk   (clk),
		.we    (cmd.update),
		.waddr (head_q),
		.wdata (rate_q),
		.raddr (head_q),
		.rdata (oldest)
	);

	// New average: cumulative while filling, adjusted by the change once full.
	always_comb begin
		mag     = quotient[AVG_W-1:0];
		avg_sum = {1'b0, avg_q} + {1'b0, mag};
		if (!full) begin
			avg_next = (|quotient[DIV_NW-1:AVG_W]) ? MAX_AVG : quotient[AVG_W-1:0];
		end else if (rising) begin
			avg_next = avg_sum[AVG_W] ? MAX_AVG : avg_sum[AVG_W-1:0];
		end else begin
			avg_next = (avg_q > mag) ? (avg_q - mag) : '0;
		end
	end

	// Window state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q   <= '0;
			count_q <= '0;
			head_q  <= '0;
		end else if (cmd.update) begin
			avg_q <= avg_next;
			if (!full) begin
				count_q <= count_q + 1'b1;
			end
			head_q <= (head_q == HEAD_W'(WINDOW - 1)) ? '0 : head_q + 1'b1;
		end
	end

	// Output register: a finished result waits here while the next beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_rate_q <= sts.us_zero ? '0 : rate_q;
			out_avg_q  <= avg_q;
			out_cnt_q  <= count_q;
			out_bad_q  <= sts.us_zero;
		end
	end

	assign sts.us_zero     = (us_q == '0);
	assign sts.div_busy    = div_busy;
	assign sts.div_done    = div_done;
	assign sts.out_free    = !out_valid_q || !out_stall;

	assign out_valid    = out_valid_q;
	assign sample_rate  = out_rate_q;
	assign average_rate = out_avg_q;
	assign bad_sample   = out_bad_q;

	// The sample count is reported in a fixed seven-bit field.
	generate
		if (CNT_W >= HELD_W) begin : g_held_cut
			assign samples_held = out_cnt_q[HELD_W-1:0];
		end else begin : g_held_ext
			assign samples_held = HELD_W'(out_cnt_q);
		end
	endgenerate

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(WINDOW))
		else $error("sample count beyond the window");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_q < HEAD_W'(WINDOW))
		else $error("ring head beyond the window");

endmodule

// File: rtl/twa_ctrl.sv
// Controller of the throughput meter: sequences capture, both divisions,
// the state update and the hand-off to the output register. Depends on twa_pkg.
module twa_ctrl import twa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  twa_sts_t sts,
	output twa_cmd_t cmd
);

	twa_state_t state_q;
	twa_state_t state_nx;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next state.
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nx = ST_MUL;
				end
			end
			ST_MUL: begin
				state_nx = sts.us_zero ? ST_RESULT : ST_RATE_GO;
			end
			ST_RATE_GO: begin
				state_nx = ST_RATE_WAIT;
			end
			ST_RATE_WAIT: begin
				if (sts.div_done) begin
					state_nx = ST_AVG_PREP;
				end
			end
			ST_AVG_PREP: begin
				state_nx = ST_AVG_GO;
			end
			ST_AVG_GO: begin
				state_nx = ST_AVG_WAIT;
			end
			ST_AVG_WAIT: begin
				if (sts.div_done) begin
					state_nx = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				state_nx = ST_RESULT;
			end
			ST_RESULT: begin
				if (sts.out_free) begin
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// Commands.
	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.load_in = in_valid;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
			end
			ST_RATE_GO: begin
				cmd.div_start = 1'b1;
			end
			ST_AVG_PREP: begin
				cmd.rate_take = 1'b1;
			end
			ST_AVG_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_avg   = 1'b1;
			end
			ST_AVG_WAIT: begin
				cmd.div_avg = 1'b1;
			end
			ST_UPDATE: begin
				cmd.div_avg = 1'b1;
				cmd.update  = 1'b1;
			end
			ST_RESULT: begin
				cmd.out_load = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	a_start_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !sts.div_busy)
		else $error("division started while the divider is busy");

	a_accept_to_mul: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == ST_MUL)
		else $error("accepted beat not followed by the multiply step");

endmodule

// File: rtl/throughput_window_average.sv
// Windowed throughput meter for one channel.
//
// Input channel (in_valid / in_stall): one beat carries byte_count and
// elapsed_us for one measured interval. Output channel (out_valid /
// out_stall): one beat per input beat, carrying the interval rate in
// bytes per second (saturated to 32 bits), the window average in unsigned
// Q32.16, the number of samples held and a flag for a dropped sample.
// A zero elapsed_us drops the sample: rate 0, flag set, window unchanged.
//
// One beat is worked on at a time. The bit-serial divider runs 55 iterations
// for the rate and 55 more for the average, and the next beat is taken only
// once the result has been loaded into the output register; a dropped
// sample skips both divisions.
//
// The output register holds a finished result while the receiver stalls; a
// result that cannot be handed over keeps the block from taking a new beat.
// Reset clears the average, the sample count and the ring position; ring
// entries are only read once written, so the ring needs no clearing.
module throughput_window_average import twa_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [RATE_W-1:0]  byte_count,
	input  logic [31:0]        elapsed_us,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [RATE_W-1:0]  sample_rate,
	output logic [AVG_W-1:0]   average_rate,
	output logic [HELD_W-1:0]  samples_held,
	output logic               bad_sample
);

	twa_cmd_t cmd;
	twa_sts_t sts;

	// Sequencer.
	twa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Arithmetic, window state and output register.
	twa_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.byte_count   (byte_count),
		.elapsed_us   (elapsed_us),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.sample_rate  (sample_rate),
		.average_rate (average_rate),
		.samples_held (samples_held),
		.bad_sample   (bad_sample)
	);

endmodule
